// ----- src/video_display_pixel_generator_macros.svh -----
// Assertion helpers shared by the pixel generator modules.
`ifndef VIDEO_DISPLAY_PIXEL_GENERATOR_MACROS_SVH
`define VIDEO_DISPLAY_PIXEL_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
`define VDPG_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define VDPG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define VDPG_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define VDPG_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ----- src/vdpg_pkg.sv -----
`timescale 1ns / 1ps
package vdpg_pkg;

  localparam int ACTIVE_LINES_DEFAULT = 192;
  localparam int QUEUE_DEPTH_DEFAULT  = 2;

  // configuration register indexes
  localparam logic [1:0] CFG_GRAPHICS_ENABLE = 2'd0;
  localparam logic [1:0] CFG_GRAPHICS_MODE   = 2'd1;
  localparam logic [1:0] CFG_COLOUR_SET      = 2'd2;

  localparam logic [3:0] CHAR_ROW_LAST = 4'd11;
  localparam logic [3:0] SG4_TOP_ROWS  = 4'd6;
  localparam logic [3:0] SG6_TOP_ROWS  = 4'd4;
  localparam logic [3:0] SG6_MID_ROWS  = 4'd8;

  localparam logic [3:0] COLOUR_BLACK = 4'd8;
  localparam logic [3:0] COLOUR_BG1   = 4'd7;
  localparam logic [3:0] COLOUR_FG1   = 4'd1;
  localparam logic [3:0] COLOUR_FG0   = 4'd0;

  // one byte's worth of work for the pixel sequencer
  typedef struct packed {
    logic        two_bit;
    logic [1:0]  shift;      // pixel index >> shift = source element
    logic [7:0]  data;
    logic [3:0]  fg;         // in 2-bit modes: palette base
    logic [3:0]  bg;
    logic [4:0]  cnt_m1;     // pixels to emit minus one
    logic        eof;
    logic [12:0] fetch_address;
    logic [3:0]  glyph_row;
  } desc_t;

  // log2 of horizontal widening per mode (4,2,1,2,1,2,1,1)
  function automatic logic [1:0] widen_log2(input logic [2:0] mode);
    logic [1:0] r;
    unique case (mode)
      3'd0:    r = 2'd2;
      3'd1:    r = 2'd1;
      3'd3:    r = 2'd1;
      3'd5:    r = 2'd1;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  // scan lines per row per mode (3,3,3,2,2,1,1,1)
  function automatic logic [1:0] line_repeat(input logic [2:0] mode);
    logic [1:0] r;
    unique case (mode)
      3'd0, 3'd1, 3'd2: r = 2'd3;
      3'd3, 3'd4:       r = 2'd2;
      default:          r = 2'd1;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] block_pattern(input logic [1:0] sel);
    logic [7:0] r;
    unique case (sel)
      2'd0:    r = 8'h00;
      2'd1:    r = 8'h0F;
      2'd2:    r = 8'hF0;
      default: r = 8'hFF;
    endcase
    return r;
  endfunction

endpackage

// ----- src/vdpg_front.sv -----
`timescale 1ns / 1ps
`include "video_display_pixel_generator_macros.svh"
module vdpg_front #(
  parameter int ACTIVE_LINES = vdpg_pkg::ACTIVE_LINES_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write_enable,
  input  logic [1:0]          cfg_index,
  input  logic [2:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          video_byte,
  input  logic                alpha_semigraphics,
  input  logic                sixfold_select,
  input  logic                invert_glyph,
  input  logic                byte_colour_set,
  input  logic [7:0]          glyph_row_bits,
  input  logic                q_full,
  output logic                push,
  output vdpg_pkg::desc_t     push_desc
);
  import vdpg_pkg::*;

  localparam logic [8:0] LINES = 9'(ACTIVE_LINES);

  logic        graphics_enable;
  logic [2:0]  graphics_mode;
  logic        colour_set;

  logic [7:0]  pixel_column;
  logic [7:0]  scan_line;
  logic [1:0]  scan_mod3;
  logic [12:0] fetch_pointer;
  logic [12:0] line_start_pointer;
  logic [3:0]  char_row;

  logic [7:0]  pixel_column_next;
  logic [7:0]  scan_line_next;
  logic [1:0]  scan_mod3_next;
  logic [12:0] fetch_pointer_next;
  logic [12:0] line_start_pointer_next;
  logic [3:0]  char_row_next;

  logic        accept;
  logic [1:0]  wlog;
  logic [5:0]  n_pix;
  logic [8:0]  remaining;
  logic        line_end;
  logic [5:0]  emitted;
  logic [8:0]  new_line;
  logic [1:0]  new_mod3;
  logic        repeat_line;
  logic        frame_end;
  logic [3:0]  fg_frame;
  logic [3:0]  bg_frame;
  logic [1:0]  sel;
  logic [12:0] fetch_inc;
  logic [3:0]  char_row_inc;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;
  assign push     = accept;

  assign fg_frame = colour_set ? COLOUR_FG1 : COLOUR_FG0;
  assign bg_frame = colour_set ? COLOUR_BG1 : COLOUR_BLACK;

  // classify the byte
  always_comb begin
    push_desc = '0;
    sel       = 2'd0;
    wlog      = 2'd0;
    push_desc.bg = bg_frame;
    if (graphics_enable) begin
      wlog              = widen_log2(graphics_mode);
      push_desc.two_bit = !graphics_mode[0];
      push_desc.shift   = wlog + {1'b0, !graphics_mode[0]};
      push_desc.data    = video_byte;
      push_desc.fg      = graphics_mode[0] ? fg_frame : {1'b0, colour_set, 2'b00};
    end else if (alpha_semigraphics) begin
      if (sixfold_select) begin
        push_desc.fg = {2'b00, video_byte[7:6]};
        priority if (char_row < SG6_TOP_ROWS) sel = video_byte[5:4];
        else if (char_row < SG6_MID_ROWS)     sel = video_byte[3:2];
        else                                  sel = video_byte[1:0];
      end else begin
        push_desc.fg = {1'b0, video_byte[6:4]} + {1'b0, byte_colour_set, 2'b00};
        sel = (char_row < SG4_TOP_ROWS) ? video_byte[3:2] : video_byte[1:0];
      end
      push_desc.data = block_pattern(sel);
    end else begin
      push_desc.fg   = fg_frame;
      push_desc.data = invert_glyph ? ~glyph_row_bits : glyph_row_bits;
    end

    // run length, cut at the end of the line
    n_pix     = 6'd8 << wlog;
    remaining = 9'd256 - {1'b0, pixel_column};
    line_end  = {3'b000, n_pix} >= remaining;
    emitted   = line_end ? remaining[5:0] : n_pix;
    push_desc.cnt_m1 = 5'(emitted - 6'd1);

    // frame counters
    fetch_inc    = fetch_pointer + 13'd1;
    new_line     = {1'b0, scan_line} + 9'd1;
    new_mod3     = (scan_mod3 == 2'd2) ? 2'd0 : scan_mod3 + 2'd1;
    char_row_inc = (char_row >= CHAR_ROW_LAST) ? 4'd0 : char_row + 4'd1;
    if (graphics_enable) begin
      unique case (line_repeat(graphics_mode))
        2'd3:    repeat_line = (new_mod3 != 2'd0);
        2'd2:    repeat_line = new_line[0];
        default: repeat_line = 1'b0;
      endcase
    end else begin
      repeat_line = (char_row != CHAR_ROW_LAST);
    end
    frame_end = line_end && (new_line >= LINES);

    pixel_column_next       = pixel_column + 8'(emitted);
    scan_line_next          = scan_line;
    scan_mod3_next          = scan_mod3;
    fetch_pointer_next      = fetch_inc;
    line_start_pointer_next = line_start_pointer;
    char_row_next           = char_row;
    if (frame_end) begin
      pixel_column_next       = 8'd0;
      scan_line_next          = 8'd0;
      scan_mod3_next          = 2'd0;
      fetch_pointer_next      = 13'd0;
      line_start_pointer_next = 13'd0;
      char_row_next           = 4'd0;
    end else if (line_end) begin
      scan_line_next = new_line[7:0];
      scan_mod3_next = new_mod3;
      char_row_next  = char_row_inc;
      if (repeat_line) fetch_pointer_next = line_start_pointer;
      else             line_start_pointer_next = fetch_inc;
    end

    push_desc.eof           = frame_end;
    push_desc.fetch_address = fetch_pointer_next;
    push_desc.glyph_row     = char_row_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      graphics_enable    <= 1'b0;
      graphics_mode      <= 3'd0;
      colour_set         <= 1'b0;
      pixel_column       <= 8'd0;
      scan_line          <= 8'd0;
      scan_mod3          <= 2'd0;
      fetch_pointer      <= 13'd0;
      line_start_pointer <= 13'd0;
      char_row           <= 4'd0;
    end else begin
      if (cfg_write_enable) begin
        unique case (cfg_index)
          CFG_GRAPHICS_ENABLE: graphics_enable <= cfg_data[0];
          CFG_GRAPHICS_MODE:   graphics_mode   <= cfg_data;
          CFG_COLOUR_SET:      colour_set      <= cfg_data[0];
          default: ;
        endcase
      end
      if (accept) begin
        pixel_column       <= pixel_column_next;
        scan_line          <= scan_line_next;
        scan_mod3          <= scan_mod3_next;
        fetch_pointer      <= fetch_pointer_next;
        line_start_pointer <= line_start_pointer_next;
        char_row           <= char_row_next;
      end
    end
  end

  `VDPG_ASSERT_NEXT(a_line_end_col, clk, rst, accept && line_end, pixel_column == 8'd0, "column not at zero after line end")
  `VDPG_ASSERT_NEXT(a_line_hold, clk, rst, accept && !line_end, scan_line == $past(scan_line), "scan line moved mid-line")
  `VDPG_ASSERT_SAME(a_mod3, clk, rst, 1'b1, scan_mod3 != 2'd3, "scan line mod-3 tracker out of range")

endmodule

// ----- src/vdpg_queue.sv -----
`timescale 1ns / 1ps
`include "video_display_pixel_generator_macros.svh"
module vdpg_queue #(
  parameter int DEPTH = vdpg_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  vdpg_pkg::desc_t push_desc,
  output logic            full,
  output logic            q_valid,
  output vdpg_pkg::desc_t head,
  input  logic            pop
);
  import vdpg_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

  desc_t          mem [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full    = (count == CW'(DEPTH));
  assign q_valid = (count != '0);
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PW'(1);
      unique case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: ;
      endcase
    end
  end

  `VDPG_ASSERT_SAME(a_no_overflow, clk, rst, push, !full, "push into full queue")
  `VDPG_ASSERT_SAME(a_no_underflow, clk, rst, pop, q_valid, "pop from empty queue")

endmodule

// ----- src/vdpg_back.sv -----
`timescale 1ns / 1ps
`include "video_display_pixel_generator_macros.svh"
module vdpg_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  vdpg_pkg::desc_t head,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [3:0]      pixel_colour,
  output logic            last_of_byte,
  output logic            end_of_frame,
  output logic [12:0]     fetch_address,
  output logic [3:0]      glyph_row
);
  import vdpg_pkg::*;

  logic [4:0] pix_idx;
  logic [4:0] src_idx;
  logic [7:0] bit_sh;
  logic [7:0] pair_sh;
  logic [3:0] colour;
  logic       load;
  logic       last;

  assign load = q_valid && (!out_valid || !out_stall);
  assign last = (pix_idx == head.cnt_m1);
  assign pop  = load && last;

  always_comb begin
    src_idx = pix_idx >> head.shift;
    bit_sh  = head.data << src_idx[2:0];
    pair_sh = head.data << {src_idx[1:0], 1'b0};
    if (head.two_bit) colour = head.fg | {2'b00, pair_sh[7:6]};
    else              colour = bit_sh[7] ? head.fg : head.bg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pix_idx   <= 5'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        pix_idx   <= last ? 5'd0 : pix_idx + 5'd1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pixel_colour  <= colour;
      last_of_byte  <= last;
      end_of_frame  <= last && head.eof;
      fetch_address <= head.fetch_address;
      glyph_row     <= head.glyph_row;
    end
  end

  `VDPG_ASSERT_NEXT(a_last_beat, clk, rst, pop, out_valid && last_of_byte, "final beat not marked")
  `VDPG_ASSERT_NEXT(a_mid_beat, clk, rst, load && !last, !last_of_byte, "mid-run beat marked last")
  `VDPG_ASSERT_SAME(a_idx_range, clk, rst, q_valid, pix_idx <= head.cnt_m1, "pixel index past run length")

endmodule

// ----- src/video_display_pixel_generator.sv -----
`timescale 1ns / 1ps
// Pixel generator for a 256-pixel-wide text/semigraphics/graphics display.
// Each accepted byte beat yields one output beat per pixel: 8 for text and
// semigraphics, 8, 16 or 32 in graphics depending on graphics_mode, fewer
// when the run reaches the end of a line. The output runs at one pixel per
// cycle while out_stall is low and a descriptor is queued; a queue of
// QUEUE_DEPTH byte descriptors lets the next bytes be accepted while the
// current run is still being shifted out. fetch_address and glyph_row on
// every pixel of a byte give the next fetch and ROM row.
module video_display_pixel_generator #(
  parameter int ACTIVE_LINES = vdpg_pkg::ACTIVE_LINES_DEFAULT,
  parameter int QUEUE_DEPTH  = vdpg_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_enable,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  video_byte,
  input  logic        alpha_semigraphics,
  input  logic        sixfold_select,
  input  logic        invert_glyph,
  input  logic        byte_colour_set,
  input  logic [7:0]  glyph_row_bits,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  pixel_colour,
  output logic        last_of_byte,
  output logic        end_of_frame,
  output logic [12:0] fetch_address,
  output logic [3:0]  glyph_row
);
  import vdpg_pkg::*;

  logic  q_full;
  logic  push;
  logic  pop;
  logic  q_valid;
  desc_t push_desc;
  desc_t head;

  vdpg_front #(
    .ACTIVE_LINES(ACTIVE_LINES)
  ) u_front (
    .clk                (clk),
    .rst                (rst),
    .cfg_write_enable   (cfg_write_enable),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .video_byte         (video_byte),
    .alpha_semigraphics (alpha_semigraphics),
    .sixfold_select     (sixfold_select),
    .invert_glyph       (invert_glyph),
    .byte_colour_set    (byte_colour_set),
    .glyph_row_bits     (glyph_row_bits),
    .q_full             (q_full),
    .push               (push),
    .push_desc          (push_desc)
  );

  vdpg_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_desc (push_desc),
    .full      (q_full),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop)
  );

  vdpg_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .pixel_colour  (pixel_colour),
    .last_of_byte  (last_of_byte),
    .end_of_frame  (end_of_frame),
    .fetch_address (fetch_address),
    .glyph_row     (glyph_row)
  );

endmodule

// ----- tb/video_display_pixel_generator_checker.sv -----
`timescale 1ns / 1ps
module video_display_pixel_generator_checker #(
  parameter int ACTIVE_LINES = 192
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_enable,
  input  logic [1:0]  cfg_index,
  input  logic [2:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  video_byte,
  input  logic        alpha_semigraphics,
  input  logic        sixfold_select,
  input  logic        invert_glyph,
  input  logic        byte_colour_set,
  input  logic [7:0]  glyph_row_bits,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [3:0]  pixel_colour,
  input  logic        last_of_byte,
  input  logic        end_of_frame,
  input  logic [12:0] fetch_address,
  input  logic [3:0]  glyph_row,
  output int          errors,
  output int          pending,
  output int          bytes_seen,
  output int          pixels_seen,
  output int          frames_seen
);
  import vdpg_pkg::*;

  typedef struct packed {
    logic [3:0]  colour;
    logic        last;
    logic        eof;
    logic [12:0] addr;
    logic [3:0]  row;
  } pixel_t;

  pixel_t expected_px [$];

  // mirrored registers and frame counters
  logic        gfx_on;
  logic [2:0]  gfx_mode;
  logic        cset;
  logic [7:0]  column;
  logic [7:0]  line_no;
  logic [12:0] fetch_ptr;
  logic [12:0] line_ptr;
  logic [3:0]  row_ctr;

  initial begin
    errors      = 0;
    pending     = 0;
    bytes_seen  = 0;
    pixels_seen = 0;
    frames_seen = 0;
  end

  task automatic note_mismatch(input string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // expand one byte into its pixel run and advance the frame counters
  task automatic render_byte(input logic [7:0] vb, input logic as_b, input logic six,
                             input logic inv, input logic bcss, input logic [7:0] glyph);
    logic [3:0] run [32];
    logic [3:0] fg;
    logic [3:0] bg;
    logic [3:0] ink;
    logic [7:0] bits;
    logic [1:0] sel;
    int         width;
    int         lines;
    int         total;
    int         shown;
    int         next_line;
    int         i;
    int         j;
    logic       line_done;
    logic       frame_done;
    logic       redo;
    pixel_t     px;
    fg = cset ? COLOUR_FG1 : COLOUR_FG0;
    bg = cset ? COLOUR_BG1 : COLOUR_BLACK;
    total = 0;
    case (gfx_mode)
      3'd0:             width = 4;
      3'd1, 3'd3, 3'd5: width = 2;
      default:          width = 1;
    endcase
    case (gfx_mode)
      3'd0, 3'd1, 3'd2: lines = 3;
      3'd3, 3'd4:       lines = 2;
      default:          lines = 1;
    endcase
    if (gfx_on) begin
      if (gfx_mode[0]) begin
        for (i = 7; i >= 0; i--) begin
          for (j = 0; j < width; j++) begin
            run[total] = vb[i] ? fg : bg;
            total++;
          end
        end
      end else begin
        // 2-bit colour, each source pixel doubled on top of the widening
        for (i = 3; i >= 0; i--) begin
          for (j = 0; j < 2 * width; j++) begin
            run[total] = {1'b0, cset, vb[2*i +: 2]};
            total++;
          end
        end
      end
    end else begin
      if (as_b) begin
        if (six) begin
          ink = {2'b00, vb[7:6]};
          if (row_ctr < SG6_TOP_ROWS) sel = vb[5:4];
          else if (row_ctr < SG6_MID_ROWS) sel = vb[3:2];
          else sel = vb[1:0];
        end else begin
          ink = {1'b0, vb[6:4]} + {1'b0, bcss, 2'b00};
          sel = (row_ctr < SG4_TOP_ROWS) ? vb[3:2] : vb[1:0];
        end
        bits = {{4{sel[1]}}, {4{sel[0]}}};
      end else begin
        ink = fg;
        bits = inv ? ~glyph : glyph;
      end
      for (i = 7; i >= 0; i--) begin
        run[total] = bits[i] ? ink : bg;
        total++;
      end
    end

    // a run that crosses the line end is cut there
    shown = 0;
    line_done = 1'b0;
    frame_done = 1'b0;
    while (shown < total && !line_done) begin
      shown++;
      column = column + 8'd1;
      if (column == 8'd0) line_done = 1'b1;
    end
    fetch_ptr = fetch_ptr + 13'd1;
    if (line_done) begin
      next_line = line_no + 1;
      if (gfx_on) redo = (next_line % lines) != 0;
      else redo = (row_ctr != CHAR_ROW_LAST);
      row_ctr = (row_ctr >= CHAR_ROW_LAST) ? 4'd0 : row_ctr + 4'd1;
      if (next_line >= ACTIVE_LINES) begin
        frame_done = 1'b1;
        column = '0;
        line_no = '0;
        fetch_ptr = '0;
        line_ptr = '0;
        row_ctr = '0;
      end else begin
        line_no = line_no + 8'd1;
        if (redo) fetch_ptr = line_ptr;
        else line_ptr = fetch_ptr;
      end
    end
    for (i = 0; i < shown; i++) begin
      px.colour = run[i];
      px.last = (i == shown - 1);
      px.eof = frame_done && (i == shown - 1);
      px.addr = fetch_ptr;
      px.row = row_ctr;
      expected_px.push_back(px);
    end
  endtask

  always @(posedge clk) begin
    pixel_t want;
    if (rst) begin
      gfx_on = 1'b0;
      gfx_mode = '0;
      cset = 1'b0;
      column = '0;
      line_no = '0;
      fetch_ptr = '0;
      line_ptr = '0;
      row_ctr = '0;
    end else begin
      if (cfg_write_enable) begin
        case (cfg_index)
          CFG_GRAPHICS_ENABLE: gfx_on = cfg_data[0];
          CFG_GRAPHICS_MODE:   gfx_mode = cfg_data;
          CFG_COLOUR_SET:      cset = cfg_data[0];
          default: ;
        endcase
      end
      // pixels leaving this edge belong to bytes taken at earlier edges
      if (out_valid && !out_stall) begin
        pixels_seen++;
        if (expected_px.size() == 0) begin
          note_mismatch($sformatf("pixel beat (colour %0d) with nothing expected",
                                  pixel_colour));
        end else begin
          want = expected_px.pop_front();
          if (pixel_colour !== want.colour)
            note_mismatch($sformatf("pixel_colour got %0d want %0d", pixel_colour,
                                    want.colour));
          if (last_of_byte !== want.last)
            note_mismatch($sformatf("last_of_byte got %b want %b", last_of_byte,
                                    want.last));
          if (end_of_frame !== want.eof)
            note_mismatch($sformatf("end_of_frame got %b want %b", end_of_frame,
                                    want.eof));
          if (fetch_address !== want.addr)
            note_mismatch($sformatf("fetch_address got %0d want %0d", fetch_address,
                                    want.addr));
          if (glyph_row !== want.row)
            note_mismatch($sformatf("glyph_row got %0d want %0d", glyph_row, want.row));
          if (want.eof) frames_seen++;
        end
      end
      if (in_valid && !in_stall) begin
        bytes_seen++;
        render_byte(video_byte, alpha_semigraphics, sixfold_select, invert_glyph,
                    byte_colour_set, glyph_row_bits);
      end
    end
    pending <= expected_px.size();
  end

endmodule

// ----- tb/video_display_pixel_generator_tb.sv -----
`timescale 1ns / 1ps
module video_display_pixel_generator_tb;
  import vdpg_pkg::*;

  // shorter frame than the default
  localparam int FRAME_LINES = 96;
  // index with no register behind it; writes must be ignored
  localparam logic [1:0] CFG_SPARE = 2'd3;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_write_enable = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [2:0]  cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  video_byte = '0;
  logic        alpha_semigraphics = 1'b0;
  logic        sixfold_select = 1'b0;
  logic        invert_glyph = 1'b0;
  logic        byte_colour_set = 1'b0;
  logic [7:0]  glyph_row_bits = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  pixel_colour;
  logic        last_of_byte;
  logic        end_of_frame;
  logic [12:0] fetch_address;
  logic [3:0]  glyph_row;

  int   errors;
  int   pending;
  int   bytes_seen;
  int   pixels_seen;
  int   frames_seen;
  logic calm = 1'b0;

  video_display_pixel_generator #(.ACTIVE_LINES(FRAME_LINES)) u_dut (
    .clk(clk), .rst(rst),
    .cfg_write_enable(cfg_write_enable), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .video_byte(video_byte), .alpha_semigraphics(alpha_semigraphics),
    .sixfold_select(sixfold_select), .invert_glyph(invert_glyph),
    .byte_colour_set(byte_colour_set), .glyph_row_bits(glyph_row_bits),
    .out_valid(out_valid), .out_stall(out_stall),
    .pixel_colour(pixel_colour), .last_of_byte(last_of_byte),
    .end_of_frame(end_of_frame), .fetch_address(fetch_address), .glyph_row(glyph_row)
  );

  video_display_pixel_generator_checker #(.ACTIVE_LINES(FRAME_LINES)) u_checker (
    .clk(clk), .rst(rst),
    .cfg_write_enable(cfg_write_enable), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .video_byte(video_byte), .alpha_semigraphics(alpha_semigraphics),
    .sixfold_select(sixfold_select), .invert_glyph(invert_glyph),
    .byte_colour_set(byte_colour_set), .glyph_row_bits(glyph_row_bits),
    .out_valid(out_valid), .out_stall(out_stall),
    .pixel_colour(pixel_colour), .last_of_byte(last_of_byte),
    .end_of_frame(end_of_frame), .fetch_address(fetch_address), .glyph_row(glyph_row),
    .errors(errors), .pending(pending), .bytes_seen(bytes_seen),
    .pixels_seen(pixels_seen), .frames_seen(frames_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #18_000_000;
    $display("timeout with %0d pixels still expected", pending);
    $display("TB_ERROR");
    $finish;
  end

  // pixel sink: random stall before each beat
  initial begin
    int hold;
    while (rst) @(posedge clk);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 5);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] vb, input logic as_b, input logic six,
                           input logic inv, input logic bcss, input logic [7:0] glyph);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    video_byte <= vb;
    alpha_semigraphics <= as_b;
    sixfold_select <= six;
    invert_glyph <= inv;
    byte_colour_set <= bcss;
    glyph_row_bits <= glyph;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_random();
    send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
  endtask

  // waits until every expected pixel is out, then writes one register
  task automatic write_reg(input logic [1:0] idx, input logic [2:0] val);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
  endtask

  initial begin
    int         random_count;
    int         run_len;
    int         m;
    logic [2:0] reg_val;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // text defaults: plain and inverted glyphs, SG4 and SG6 blocks
    send_byte(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, 8'hFF);
    send_byte(8'hFF, 1'b0, 1'b1, 1'b1, 1'b1, 8'hFF);
    send_byte(8'hA5, 1'b0, 1'b0, 1'b1, 1'b0, 8'h81);
    send_byte(8'h00, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00);
    send_byte(8'hFF, 1'b1, 1'b0, 1'b0, 1'b1, 8'h00);
    send_byte(8'h7B, 1'b1, 1'b0, 1'b1, 1'b0, 8'h5A);
    send_byte(8'hC0, 1'b1, 1'b1, 1'b0, 1'b0, 8'hFF);
    send_byte(8'h3F, 1'b1, 1'b1, 1'b1, 1'b1, 8'h00);
    write_reg(CFG_COLOUR_SET, 3'd1);
    send_byte(8'h5C, 1'b0, 1'b0, 1'b0, 1'b0, 8'h3C);

    // every graphics mode, both palette halves
    write_reg(CFG_GRAPHICS_ENABLE, 3'd1);
    for (m = 0; m < 8; m++) begin
      write_reg(CFG_GRAPHICS_MODE, m[2:0]);
      write_reg(CFG_COLOUR_SET, {2'b00, m[1]});
      send_byte(8'hE4, m[0], m[1], m[2], 1'b0, 8'h00);
      send_byte(m[0] ? 8'hFF : 8'h1B, 1'b1, 1'b0, 1'b1, 1'b1, 8'hFF);
    end

    // random settings; upper data bits of the 1-bit registers must not matter
    random_count = 0;
    while (random_count < 330) begin
      calm = ($urandom_range(0, 4) == 0);
      reg_val = 3'($urandom_range(0, 7));
      write_reg(CFG_GRAPHICS_MODE, reg_val);
      reg_val = 3'($urandom_range(0, 7));
      write_reg(CFG_GRAPHICS_ENABLE, reg_val);
      reg_val = 3'($urandom_range(0, 7));
      write_reg(CFG_COLOUR_SET, reg_val);
      if ($urandom_range(0, 5) == 0) begin
        reg_val = 3'($urandom_range(0, 7));
        write_reg(CFG_SPARE, reg_val);
      end
      run_len = $urandom_range(20, 60);
      repeat (run_len) begin
        send_random();
        random_count++;
      end
    end

    // widest mode: long runs and runs cut at the line end
    calm = 1'b0;
    write_reg(CFG_GRAPHICS_ENABLE, 3'd1);
    write_reg(CFG_GRAPHICS_MODE, 3'd0);
    reg_val = 3'($urandom_range(0, 1));
    write_reg(CFG_COLOUR_SET, reg_val);
    repeat (64) send_random();

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);

    $display("ran %0d bytes into %0d pixels over text, semigraphics and all graphics modes",
             bytes_seen, pixels_seen);
    $display("frame wraps seen: %0d, mismatches: %0d", frames_seen, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
